/* rtl/traffic_light_day_night_sequencer_core_macros.svh */
// Assertion macros for the traffic light day/night sequencer core
`ifndef TRAFFIC_LIGHT_DAY_NIGHT_SEQUENCER_CORE_MACROS_SVH
`define TRAFFIC_LIGHT_DAY_NIGHT_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TLDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TLDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TLDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TLDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/tlds_pkg.sv */
// Shared types, constants and helpers for the traffic light day/night sequencer
package tlds_pkg;

   localparam int TICKS_PER_SECOND = 20;
   localparam int TICK_W           = 6;
   localparam int LIGHT_W          = 12;
   localparam int SECS_W           = 7;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 12;

   localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);
   localparam logic [TICK_W-1:0] LIT_TICKS = TICK_W'((TICKS_PER_SECOND + 1) / 2);

   localparam logic [SECS_W-1:0] SECS_MIN = SECS_W'(1);
   localparam logic [SECS_W-1:0] SECS_MAX = SECS_W'(99);

   localparam logic [LIGHT_W-1:0] DARK_THRESHOLD_RESET = LIGHT_W'(1000);
   localparam logic [SECS_W-1:0]  PHASE_SECONDS_RESET  = SECS_W'(8);
   localparam logic [SECS_W-1:0]  SECONDS_LEFT_RESET   = SECS_W'(8);

   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_SECONDS  = 1'b1;

   localparam logic [1:0] PHASE_RED    = 2'd0;
   localparam logic [1:0] PHASE_GREEN  = 2'd1;
   localparam logic [1:0] PHASE_YELLOW = 2'd2;

   localparam logic [1:0] DISP_BLANK  = 2'd0;
   localparam logic [1:0] DISP_COUNT  = 2'd1;
   localparam logic [1:0] DISP_DASHES = 2'd2;

   typedef struct packed {
      logic              night;
      logic              visible;
      logic              last_button;
      logic [1:0]        phase;
      logic [SECS_W-1:0] seconds_left;
      logic [TICK_W-1:0] tick;
   } state_type;

   typedef struct packed {
      logic              red_lamp;
      logic              yellow_lamp;
      logic              green_lamp;
      logic              status_led;
      logic [1:0]        display_mode;
      logic [SECS_W-1:0] display_count;
      logic              mode_changed;
   } result_type;

   function automatic logic [SECS_W-1:0] phase_length(input logic [SECS_W-1:0] secs);
      logic [SECS_W-1:0] len;
      len = secs;
      if (len < SECS_MIN) len = SECS_MIN;
      if (len > SECS_MAX) len = SECS_MAX;
      return len;
   endfunction

endpackage

/* rtl/tlds_step.sv */
// Per-tick next-state and result logic of the sequencer
module tlds_step
   import tlds_pkg::*;
(
   input  state_type          cur,
   input  logic [LIGHT_W-1:0] dark_threshold,
   input  logic [SECS_W-1:0]  phase_seconds,
   input  logic               button_level,
   input  logic [LIGHT_W-1:0] light_level,
   output state_type          nxt,
   output result_type         res
);

   logic              dark;
   logic              changed;
   logic              lit;
   logic              visible;
   logic [SECS_W-1:0] plen;

   always_comb begin
      visible = cur.visible ^ (cur.last_button & ~button_level);
      dark    = (light_level < dark_threshold);
      changed = (dark != cur.night);
      lit     = (cur.tick < LIT_TICKS);
      plen    = phase_length(phase_seconds);

      res              = '0;
      res.status_led   = visible;
      res.mode_changed = changed;
      if (!changed) begin
         if (cur.night) begin
            res.yellow_lamp = lit;
         end else begin
            case (cur.phase)
               PHASE_RED:   res.red_lamp    = lit;
               PHASE_GREEN: res.green_lamp  = lit;
               default:     res.yellow_lamp = lit;
            endcase
         end
      end

      if (!visible) begin
         res.display_mode = DISP_BLANK;
      end else if (dark) begin
         res.display_mode = DISP_DASHES;
      end else begin
         res.display_mode  = DISP_COUNT;
         res.display_count = changed ? plen : cur.seconds_left;
      end

      nxt             = cur;
      nxt.visible     = visible;
      nxt.last_button = button_level;
      if (changed) begin
         nxt.night        = dark;
         nxt.phase        = PHASE_RED;
         nxt.seconds_left = plen;
         nxt.tick         = '0;
      end else if (cur.tick >= TICK_LAST) begin
         nxt.tick = '0;
         if (!cur.night) begin
            if (cur.seconds_left <= SECS_MIN) begin
               nxt.phase        = (cur.phase >= PHASE_YELLOW) ? PHASE_RED : cur.phase + 2'd1;
               nxt.seconds_left = plen;
            end else begin
               nxt.seconds_left = cur.seconds_left - SECS_MIN;
            end
         end
      end else begin
         nxt.tick = cur.tick + TICK_W'(1);
      end
   end

endmodule

/* rtl/traffic_light_day_night_sequencer_core.sv */
// Each accepted tick's result is registered and shows on the rsp_ outputs in the next cycle.
// Throughput: one tick per cycle; a new tick is taken while the result register
// drains, and req_stall rises only while a held result is itself stalled.
// Reset: synchronous, clears to day mode, red phase, 8 seconds, display visible,
// threshold 1000 and phase length 8; no result pending.
`include "traffic_light_day_night_sequencer_core_macros.svh"
module traffic_light_day_night_sequencer_core
   import tlds_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_button_level,
   input  logic [LIGHT_W-1:0]     req_light_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_red_lamp,
   output logic                   rsp_yellow_lamp,
   output logic                   rsp_green_lamp,
   output logic                   rsp_status_led,
   output logic [1:0]             rsp_display_mode,
   output logic [SECS_W-1:0]      rsp_display_count,
   output logic                   rsp_mode_changed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   state_type          state_ff;
   state_type          state_in;
   result_type         rsp_ff;
   result_type         rsp_in;
   logic               rsp_valid_ff;
   logic [LIGHT_W-1:0] dark_threshold_ff;
   logic [SECS_W-1:0]  phase_seconds_ff;
   logic               req_xfer;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;

   tlds_step u_step (
      .cur            (state_ff),
      .dark_threshold (dark_threshold_ff),
      .phase_seconds  (phase_seconds_ff),
      .button_level   (req_button_level),
      .light_level    (req_light_level),
      .nxt            (state_in),
      .res            (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff <= DARK_THRESHOLD_RESET;
         phase_seconds_ff  <= PHASE_SECONDS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_data[LIGHT_W-1:0];
            CSR_PHASE_SECONDS:  phase_seconds_ff  <= csr_data[SECS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.night        <= 1'b0;
         state_ff.visible      <= 1'b1;
         state_ff.last_button  <= 1'b1;
         state_ff.phase        <= PHASE_RED;
         state_ff.seconds_left <= SECONDS_LEFT_RESET;
         state_ff.tick         <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_lamp      = rsp_ff.red_lamp;
   assign rsp_yellow_lamp   = rsp_ff.yellow_lamp;
   assign rsp_green_lamp    = rsp_ff.green_lamp;
   assign rsp_status_led    = rsp_ff.status_led;
   assign rsp_display_mode  = rsp_ff.display_mode;
   assign rsp_display_count = rsp_ff.display_count;
   assign rsp_mode_changed  = rsp_ff.mode_changed;

   `TLDS_ASSERT_IMPL(a_one_lamp, clock, reset, rsp_valid_ff, $onehot0({rsp_ff.red_lamp, rsp_ff.yellow_lamp, rsp_ff.green_lamp}), "more than one lamp lit")
   `TLDS_ASSERT_IMPL(a_flip_dark, clock, reset, rsp_valid_ff && rsp_ff.mode_changed, !rsp_ff.red_lamp && !rsp_ff.yellow_lamp && !rsp_ff.green_lamp, "lamp lit on mode flip")
   `TLDS_ASSERT_IMPL(a_secs_range, clock, reset, 1'b1, state_ff.seconds_left >= SECS_MIN && state_ff.seconds_left <= SECS_MAX, "seconds left out of range")
   `TLDS_ASSERT_IMPL(a_led_display, clock, reset, rsp_valid_ff, rsp_ff.status_led == (rsp_ff.display_mode != DISP_BLANK), "status LED disagrees with display")
   `TLDS_ASSERT_NEXT(a_xfer_result, clock, reset, req_xfer, rsp_valid_ff, "transfer produced no result")

endmodule
